// File: hdl/sbht_pkg.sv
// Shared types, constants and helper functions for the scoreboard hazard tracker.
// Used by the controller, the datapath and the top level; depends on nothing else.

package sbht_pkg;

   // Functional units and their tags.
   localparam int NUM_UNITS = 5;
   localparam int UNIT_W    = 3;
   localparam logic [UNIT_W-1:0] UNIT_INT  = 3'd0;
   localparam logic [UNIT_W-1:0] UNIT_ALU  = 3'd1;
   localparam logic [UNIT_W-1:0] UNIT_MUL1 = 3'd2;
   localparam logic [UNIT_W-1:0] UNIT_MUL2 = 3'd3;
   localparam logic [UNIT_W-1:0] UNIT_DIV  = 3'd4;
   localparam logic [UNIT_W-1:0] NO_UNIT   = 3'd5;

   // Register numbers; a unit slot holds the none marker when unused.
   localparam int REG_COUNT = 32;
   localparam int REG_AW    = $clog2(REG_COUNT);
   localparam int REG_NUM_W = 5;
   localparam int SLOT_W    = 6;
   localparam logic [SLOT_W-1:0] NO_REG = 6'd63;

   // Operation codes.
   localparam logic [1:0] OP_QUERY = 2'd0;
   localparam logic [1:0] OP_ISSUE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_WB    = 2'd3;

   // Unit class codes.
   localparam logic [2:0] CLS_ALU  = 3'd0;
   localparam logic [2:0] CLS_ADDR = 3'd1;
   localparam logic [2:0] CLS_MEM  = 3'd2;
   localparam logic [2:0] CLS_MUL  = 3'd3;
   localparam logic [2:0] CLS_DIV  = 3'd4;

   // Latency registers and their indexes on the register port.
   localparam int LAT_W     = 20;
   localparam int NUM_LAT   = 5;
   localparam int CSR_AW    = 5;
   localparam int CSR_DW    = 32;
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_ALU_LAT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ADDR_LAT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MEM_LAT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MUL_LAT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DIV_LAT  = 3'd4;
   localparam logic [LAT_W-1:0] ALU_LAT_RST  = 20'd1;
   localparam logic [LAT_W-1:0] ADDR_LAT_RST = 20'd2;
   localparam logic [LAT_W-1:0] MEM_LAT_RST  = 20'd666666;
   localparam logic [LAT_W-1:0] MUL_LAT_RST  = 20'd3;
   localparam logic [LAT_W-1:0] DIV_LAT_RST  = 20'd7;

   // Per-unit scoreboard entry.
   typedef struct packed {
      logic              busy;
      logic [SLOT_W-1:0] dest;
      logic [SLOT_W-1:0] src1;
      logic [SLOT_W-1:0] src2;
      logic [UNIT_W-1:0] tag1;
      logic [UNIT_W-1:0] tag2;
      logic              ready1;
      logic              ready2;
   } unit_entry_type;

   localparam unit_entry_type UNIT_FREE = '{
      busy: 1'b0, dest: NO_REG, src1: NO_REG, src2: NO_REG,
      tag1: NO_UNIT, tag2: NO_UNIT, ready1: 1'b0, ready2: 1'b0};

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic read1;
      logic read2;
      logic commit;
   } cmd_type;

   // A register number has a table entry only below REG_COUNT.
   function automatic logic reg_tracked(input logic [REG_NUM_W-1:0] r);
      return 7'(r) < 7'(REG_COUNT);
   endfunction

   // Table address of a register number.
   function automatic logic [REG_AW-1:0] reg_index(input logic [REG_NUM_W-1:0] r);
      logic [6:0] wide;
      wide = 7'(r);
      return wide[REG_AW-1:0];
   endfunction

endpackage

// File: hdl/sbht_ctrl.sv
// Controller of the scoreboard hazard tracker: sequences one word through
// two table read steps and a commit step, and owns the result valid flag.
// Depends on sbht_pkg.

module sbht_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sbht_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_READ1 = 4'b0010,
      ST_READ2 = 4'b0100,
      ST_EXEC  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   // The result register can take a new word when empty or being drained.
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands.
   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.read1   = 1'b0;
      cmd.read2   = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_READ1;
            end
         end
         ST_READ1: begin
            cmd.read1 = 1'b1;
            state_in  = ST_READ2;
         end
         ST_READ2: begin
            cmd.read2 = 1'b1;
            state_in  = ST_EXEC;
         end
         ST_EXEC: begin
            if (slot_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result valid is set on commit and cleared when the word is taken.
   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: hdl/sbht_dpath.sv
// Datapath of the scoreboard hazard tracker: unit status entries, the
// register producer table, latency registers, hazard checks and result register.
// Depends on sbht_pkg; driven by commands from sbht_ctrl.

module sbht_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sbht_pkg::cmd_type                    cmd,
   input  logic [1:0]                           req_op,
   input  logic [2:0]                           req_unit_class,
   input  logic                                 req_dest_valid,
   input  logic [sbht_pkg::REG_NUM_W-1:0]       req_dest_reg,
   input  logic                                 req_src1_valid,
   input  logic [sbht_pkg::REG_NUM_W-1:0]       req_src1_reg,
   input  logic                                 req_src2_valid,
   input  logic [sbht_pkg::REG_NUM_W-1:0]       req_src2_reg,
   input  logic [sbht_pkg::UNIT_W-1:0]          req_unit_id,
   input  logic                                 csr_wen,
   input  logic [sbht_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sbht_pkg::CSR_DW-1:0]          csr_wdata,
   output logic [sbht_pkg::CSR_DW-1:0]          csr_rdata,
   output logic                                 rsp_unit_free,
   output logic                                 rsp_dest_free,
   output logic                                 rsp_src_ready,
   output logic                                 rsp_war_clear,
   output logic                                 rsp_issued,
   output logic [sbht_pkg::UNIT_W-1:0]          rsp_assigned_unit,
   output logic [sbht_pkg::LAT_W-1:0]           rsp_latency
);

   // Captured input word.
   logic [1:0]                     op_ff;
   logic [2:0]                     cls_ff;
   logic                           dv_ff, s1v_ff, s2v_ff;
   logic [sbht_pkg::REG_NUM_W-1:0] dr_ff, s1_ff, s2_ff;
   logic [sbht_pkg::UNIT_W-1:0]    uid_ff;

   // Scoreboard state.
   sbht_pkg::unit_entry_type       unit_ff [sbht_pkg::NUM_UNITS];
   sbht_pkg::unit_entry_type       unit_in [sbht_pkg::NUM_UNITS];
   logic [sbht_pkg::LAT_W-1:0]     lat_ff  [sbht_pkg::NUM_LAT];

   // Producer table memory with per-entry valid bits.
   logic [sbht_pkg::UNIT_W-1:0]    prod_mem [sbht_pkg::REG_COUNT];
   logic [sbht_pkg::REG_COUNT-1:0] prod_vld_ff;
   logic [sbht_pkg::REG_NUM_W-1:0] rd_reg_a, rd_reg_b;
   logic                           rd_trk_a, rd_trk_b;
   logic [sbht_pkg::REG_AW-1:0]    rd_idx_a, rd_idx_b;
   logic [sbht_pkg::UNIT_W-1:0]    rd_a_ff, rd_b_ff;
   logic                           hit_a_ff, hit_b_ff;
   logic [sbht_pkg::UNIT_W-1:0]    prod_a, prod_b;
   logic [sbht_pkg::UNIT_W-1:0]    pd_dest_ff, pd_s1_ff;
   logic                           mem_we;
   logic [sbht_pkg::REG_AW-1:0]    mem_waddr;
   logic [sbht_pkg::UNIT_W-1:0]    mem_wdata;

   // Checks.
   logic                           uid_ok;
   logic [sbht_pkg::UNIT_W-1:0]    uid_sel;
   sbht_pkg::unit_entry_type       uid_entry;
   logic [sbht_pkg::UNIT_W-1:0]    pick_unit;
   logic [sbht_pkg::LAT_W-1:0]     pick_lat;
   logic                           unit_free, dest_free, src_ready, war_clear;
   logic                           issue_ok, wb_ok;
   logic [sbht_pkg::SLOT_W-1:0]    dr_slot;
   logic [sbht_pkg::UNIT_W-1:0]    tag1_new, tag2_new;

   // Input capture.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_op;
         cls_ff <= req_unit_class;
         dv_ff  <= req_dest_valid;
         dr_ff  <= req_dest_reg;
         s1v_ff <= req_src1_valid;
         s1_ff  <= req_src1_reg;
         s2v_ff <= req_src2_valid;
         s2_ff  <= req_src2_reg;
         uid_ff <= req_unit_id;
      end
   end

   assign uid_ok    = uid_ff < sbht_pkg::UNIT_W'(sbht_pkg::NUM_UNITS);
   assign uid_sel   = uid_ok ? uid_ff : sbht_pkg::UNIT_INT;
   assign uid_entry = unit_ff[uid_sel];

   // Table read addresses: destination and first source, then second source
   // and the destination held by the unit named in the word.
   always_comb begin
      if (cmd.read1) begin
         rd_reg_a = dr_ff;
         rd_trk_a = sbht_pkg::reg_tracked(dr_ff);
         rd_reg_b = s1_ff;
         rd_trk_b = sbht_pkg::reg_tracked(s1_ff);
      end else begin
         rd_reg_a = s2_ff;
         rd_trk_a = sbht_pkg::reg_tracked(s2_ff);
         rd_reg_b = uid_entry.dest[sbht_pkg::REG_NUM_W-1:0];
         rd_trk_b = !uid_entry.dest[sbht_pkg::SLOT_W-1] &&
                    sbht_pkg::reg_tracked(uid_entry.dest[sbht_pkg::REG_NUM_W-1:0]);
      end
   end

   assign rd_idx_a = sbht_pkg::reg_index(rd_reg_a);
   assign rd_idx_b = sbht_pkg::reg_index(rd_reg_b);

   // Registered table reads; an unwritten or untracked entry has no producer.
   always_ff @(posedge clock) begin
      if (cmd.read1 || cmd.read2) begin
         rd_a_ff  <= prod_mem[rd_idx_a];
         rd_b_ff  <= prod_mem[rd_idx_b];
         hit_a_ff <= rd_trk_a && prod_vld_ff[rd_idx_a];
         hit_b_ff <= rd_trk_b && prod_vld_ff[rd_idx_b];
      end
   end

   assign prod_a = hit_a_ff ? rd_a_ff : sbht_pkg::NO_UNIT;
   assign prod_b = hit_b_ff ? rd_b_ff : sbht_pkg::NO_UNIT;

   // Hold the first pair of producers while the second pair is read.
   always_ff @(posedge clock) begin
      if (cmd.read2) begin
         pd_dest_ff <= prod_a;
         pd_s1_ff   <= prod_b;
      end
   end

   // Unit selection for the class, with its freeness and latency.
   always_comb begin
      pick_unit = sbht_pkg::NO_UNIT;
      pick_lat  = '0;
      unit_free = 1'b1;
      case (cls_ff)
         sbht_pkg::CLS_ALU: begin
            pick_unit = sbht_pkg::UNIT_ALU;
            pick_lat  = lat_ff[sbht_pkg::CSR_ALU_LAT];
            unit_free = !unit_ff[sbht_pkg::UNIT_ALU].busy;
         end
         sbht_pkg::CLS_ADDR: begin
            pick_unit = sbht_pkg::UNIT_INT;
            pick_lat  = lat_ff[sbht_pkg::CSR_ADDR_LAT];
            unit_free = !unit_ff[sbht_pkg::UNIT_INT].busy;
         end
         sbht_pkg::CLS_MEM: begin
            pick_unit = sbht_pkg::UNIT_INT;
            pick_lat  = lat_ff[sbht_pkg::CSR_MEM_LAT];
            unit_free = !unit_ff[sbht_pkg::UNIT_INT].busy;
         end
         sbht_pkg::CLS_MUL: begin
            pick_unit = unit_ff[sbht_pkg::UNIT_MUL1].busy ? sbht_pkg::UNIT_MUL2
                                                          : sbht_pkg::UNIT_MUL1;
            pick_lat  = lat_ff[sbht_pkg::CSR_MUL_LAT];
            unit_free = !unit_ff[sbht_pkg::UNIT_MUL1].busy ||
                        !unit_ff[sbht_pkg::UNIT_MUL2].busy;
         end
         sbht_pkg::CLS_DIV: begin
            pick_unit = sbht_pkg::UNIT_DIV;
            pick_lat  = lat_ff[sbht_pkg::CSR_DIV_LAT];
            unit_free = !unit_ff[sbht_pkg::UNIT_DIV].busy;
         end
         default: begin
            pick_unit = sbht_pkg::NO_UNIT;
         end
      endcase
   end

   // Hazard checks against the state before this word.
   assign dr_slot   = sbht_pkg::SLOT_W'(dr_ff);
   assign dest_free = !dv_ff || (dr_ff == '0) || (pd_dest_ff == sbht_pkg::NO_UNIT);

   always_comb begin
      src_ready = 1'b1;
      if (uid_ok) begin
         if (uid_entry.src1 != sbht_pkg::NO_REG && !uid_entry.ready1) begin
            src_ready = 1'b0;
         end
         if (uid_entry.src2 != sbht_pkg::NO_REG && !uid_entry.ready2) begin
            src_ready = 1'b0;
         end
      end
   end

   // A unit that still has to read dest_reg blocks the write.
   always_comb begin
      war_clear = 1'b1;
      if (dv_ff) begin
         for (int i = 0; i < sbht_pkg::NUM_UNITS; i++) begin
            if ((unit_ff[i].src1 == dr_slot && unit_ff[i].ready1) ||
                (unit_ff[i].src2 == dr_slot && unit_ff[i].ready2)) begin
               war_clear = 1'b0;
            end
         end
      end
   end

   assign issue_ok = (op_ff == sbht_pkg::OP_ISSUE) && (pick_unit != sbht_pkg::NO_UNIT) &&
                     unit_free && dest_free;
   assign wb_ok    = (op_ff == sbht_pkg::OP_WB) && uid_ok;
   assign tag1_new = s1v_ff ? pd_s1_ff : sbht_pkg::NO_UNIT;
   assign tag2_new = s2v_ff ? prod_a : sbht_pkg::NO_UNIT;

   // Next unit entries for issue, operands read and writeback.
   always_comb begin
      for (int i = 0; i < sbht_pkg::NUM_UNITS; i++) begin
         unit_in[i] = unit_ff[i];
         case (op_ff)
            sbht_pkg::OP_ISSUE: begin
               if (issue_ok && pick_unit == sbht_pkg::UNIT_W'(i)) begin
                  unit_in[i].busy   = 1'b1;
                  unit_in[i].dest   = dv_ff ? dr_slot : sbht_pkg::NO_REG;
                  unit_in[i].src1   = s1v_ff ? sbht_pkg::SLOT_W'(s1_ff) : sbht_pkg::NO_REG;
                  unit_in[i].src2   = s2v_ff ? sbht_pkg::SLOT_W'(s2_ff) : sbht_pkg::NO_REG;
                  unit_in[i].tag1   = tag1_new;
                  unit_in[i].tag2   = tag2_new;
                  unit_in[i].ready1 = (tag1_new == sbht_pkg::NO_UNIT);
                  unit_in[i].ready2 = (tag2_new == sbht_pkg::NO_UNIT);
               end
            end
            sbht_pkg::OP_READ: begin
               if (uid_ok && uid_ff == sbht_pkg::UNIT_W'(i)) begin
                  unit_in[i].ready1 = 1'b0;
                  unit_in[i].ready2 = 1'b0;
                  unit_in[i].tag1   = sbht_pkg::NO_UNIT;
                  unit_in[i].tag2   = sbht_pkg::NO_UNIT;
               end
            end
            sbht_pkg::OP_WB: begin
               if (wb_ok) begin
                  // Wake every source waiting on the finishing unit.
                  if (unit_ff[i].tag1 == uid_ff) begin
                     unit_in[i].ready1 = 1'b1;
                     unit_in[i].tag1   = sbht_pkg::NO_UNIT;
                  end
                  if (unit_ff[i].tag2 == uid_ff) begin
                     unit_in[i].ready2 = 1'b1;
                     unit_in[i].tag2   = sbht_pkg::NO_UNIT;
                  end
                  if (uid_ff == sbht_pkg::UNIT_W'(i)) begin
                     unit_in[i] = sbht_pkg::UNIT_FREE;
                  end
               end
            end
            default: begin
               unit_in[i] = unit_ff[i];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < sbht_pkg::NUM_UNITS; i++) begin
            unit_ff[i] <= sbht_pkg::UNIT_FREE;
         end
      end else if (cmd.commit) begin
         for (int i = 0; i < sbht_pkg::NUM_UNITS; i++) begin
            unit_ff[i] <= unit_in[i];
         end
      end
   end

   // Producer table write: mark at issue, unmark at writeback if still ours.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = sbht_pkg::reg_index(dr_ff);
      mem_wdata = pick_unit;
      if (issue_ok) begin
         mem_we = dv_ff && (dr_ff != '0) && sbht_pkg::reg_tracked(dr_ff);
      end else if (wb_ok) begin
         mem_we    = (prod_b == uid_ff);
         mem_waddr = sbht_pkg::reg_index(uid_entry.dest[sbht_pkg::REG_NUM_W-1:0]);
         mem_wdata = sbht_pkg::NO_UNIT;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && mem_we) begin
         prod_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= '0;
      end else if (cmd.commit && mem_we) begin
         prod_vld_ff[mem_waddr] <= 1'b1;
      end
   end

   // Latency registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         lat_ff[sbht_pkg::CSR_ALU_LAT]  <= sbht_pkg::ALU_LAT_RST;
         lat_ff[sbht_pkg::CSR_ADDR_LAT] <= sbht_pkg::ADDR_LAT_RST;
         lat_ff[sbht_pkg::CSR_MEM_LAT]  <= sbht_pkg::MEM_LAT_RST;
         lat_ff[sbht_pkg::CSR_MUL_LAT]  <= sbht_pkg::MUL_LAT_RST;
         lat_ff[sbht_pkg::CSR_DIV_LAT]  <= sbht_pkg::DIV_LAT_RST;
      end else if (csr_wen && csr_index < sbht_pkg::CSR_IDX_W'(sbht_pkg::NUM_LAT)) begin
         lat_ff[csr_index] <= csr_wdata[sbht_pkg::LAT_W-1:0];
      end
   end

   // Register read; addresses past the list read as zero.
   always_comb begin
      if (csr_index < sbht_pkg::CSR_IDX_W'(sbht_pkg::NUM_LAT)) begin
         csr_rdata = sbht_pkg::CSR_DW'(lat_ff[csr_index]);
      end else begin
         csr_rdata = '0;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_unit_free     <= unit_free;
         rsp_dest_free     <= dest_free;
         rsp_src_ready     <= src_ready;
         rsp_war_clear     <= war_clear;
         rsp_issued        <= issue_ok;
         rsp_assigned_unit <= issue_ok ? pick_unit : sbht_pkg::NO_UNIT;
         rsp_latency       <= issue_ok ? pick_lat : '0;
      end
   end

endmodule

// File: hdl/scoreboard_hazard_tracker_unit.sv
// Scoreboard hazard tracker for five functional units (int/mem, ALU, two
// multipliers, divider) with a register producer table.
//
// Usage: a request word (op, unit class, destination, two sources, unit id)
// is taken on req_valid/req_ready. Every word returns exactly one response
// word on rsp_valid/rsp_ready with the structural, WAW, operand-ready and WAR
// checks taken from the state before the word, plus the issue outcome.
// Latency registers sit on an APB-style port at byte addresses 0, 4, 8, 12
// and 16; write them only while no request is in flight.
//
// Timing: a request occupies the block through capture, two producer table
// reads over its two read ports, and commit; the response is registered at
// commit, and no new request is taken until the last one has committed.
// The two-port producer table is why the reads take two steps.
// Stalls: the response stays in its output register until taken; the next
// request is accepted meanwhile and waits in the commit cycle until the
// output register is free.
// Reset: synchronous; all units are freed, the producer table reads as empty
// at once through per-entry valid bits, and latencies return to defaults.

module scoreboard_hazard_tracker_unit (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel.
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_op,
   input  logic [2:0]                         req_unit_class,
   input  logic                               req_dest_valid,
   input  logic [sbht_pkg::REG_NUM_W-1:0]     req_dest_reg,
   input  logic                               req_src1_valid,
   input  logic [sbht_pkg::REG_NUM_W-1:0]     req_src1_reg,
   input  logic                               req_src2_valid,
   input  logic [sbht_pkg::REG_NUM_W-1:0]     req_src2_reg,
   input  logic [sbht_pkg::UNIT_W-1:0]        req_unit_id,
   // Response channel.
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_unit_free,
   output logic                               rsp_dest_free,
   output logic                               rsp_src_ready,
   output logic                               rsp_war_clear,
   output logic                               rsp_issued,
   output logic [sbht_pkg::UNIT_W-1:0]        rsp_assigned_unit,
   output logic [sbht_pkg::LAT_W-1:0]         rsp_latency,
   // Register port.
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [sbht_pkg::CSR_AW-1:0]        csr_paddr,
   input  logic [sbht_pkg::CSR_DW-1:0]        csr_pwdata,
   output logic [sbht_pkg::CSR_DW-1:0]        csr_prdata,
   output logic                               csr_pready
);

   sbht_pkg::cmd_type                  cmd;
   logic                               csr_wen;
   logic [sbht_pkg::CSR_IDX_W-1:0]     csr_index;

   // The register port never waits; a write lands in the access cycle.
   assign csr_pready = 1'b1;
   assign csr_wen    = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[sbht_pkg::CSR_AW-1:2];

   sbht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   sbht_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_op            (req_op),
      .req_unit_class    (req_unit_class),
      .req_dest_valid    (req_dest_valid),
      .req_dest_reg      (req_dest_reg),
      .req_src1_valid    (req_src1_valid),
      .req_src1_reg      (req_src1_reg),
      .req_src2_valid    (req_src2_valid),
      .req_src2_reg      (req_src2_reg),
      .req_unit_id       (req_unit_id),
      .csr_wen           (csr_wen),
      .csr_index         (csr_index),
      .csr_wdata         (csr_pwdata),
      .csr_rdata         (csr_prdata),
      .rsp_unit_free     (rsp_unit_free),
      .rsp_dest_free     (rsp_dest_free),
      .rsp_src_ready     (rsp_src_ready),
      .rsp_war_clear     (rsp_war_clear),
      .rsp_issued        (rsp_issued),
      .rsp_assigned_unit (rsp_assigned_unit),
      .rsp_latency       (rsp_latency)
   );

endmodule
